@@ rtl/ccr_pkg.sv @@
// ccr_pkg: shared types and constants for the clock replacement block.
// Holds the operation codes, the controller states and the fixed field widths.
// No dependencies.
`default_nettype none

package ccr_pkg;

    // Fixed field widths of the stream payload
    localparam int SET_FIELD_W   = 8;
    localparam int WAY_FIELD_W   = 3;
    localparam int MODE_FIELD_W  = 2;
    localparam int TDATA_W       = 16;
    localparam int SET_LUT_DEPTH = 2 ** SET_FIELD_W;

    // Operation codes carried in s_tuser
    typedef enum logic [MODE_FIELD_W-1:0] {
        MODE_TOUCH  = 2'd0,
        MODE_FILL   = 2'd1,
        MODE_INVAL  = 2'd2,
        MODE_VICTIM = 2'd3
    } mode_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR  = 2'd0,
        ST_IDLE   = 2'd1,
        ST_MODIFY = 2'd2
    } state_t;

endpackage

`default_nettype wire

@@ rtl/ccr_ram.sv @@
// ccr_ram: generic simple dual-port RAM, one write and one registered read port.
// Used for the per-set replacement state. No dependencies.
`default_nettype none

module ccr_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 256
) (
    input  wire logic                                  aclk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds while no read is issued
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/clock_cache_replacement.sv @@
// clock_cache_replacement: CLOCK (second chance) replacement state for a cache.
// Per-set reference bits and hand live in ccr_ram; uses ccr_pkg.
//
//  channel  | dir | tdata (low bit up)                 | tuser
//  ---------+-----+------------------------------------+-------------
//  s_       | in  | set_index[7:0], way[10:8], pad     | mode[1:0]
//  m_       | out | victim_set[7:0], victim_way[10:8]  | -
//
// Each transaction has two steps: a RAM read of the set's entry, then the
// sweep (rotated priority encode) and write-back of the same entry.
// After reset a clearing pass writes every set before the first input
// transaction is taken.
// A victim request waits in the write-back cycle while the output register
// still holds an untaken result; other operations do not wait.
`default_nettype none

module clock_cache_replacement
    import ccr_pkg::*;
#(
    parameter int NUM_SETS = 256,
    parameter int NUM_WAYS = 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,   // set_index[7:0], way[10:8], zero pad
    input  wire logic [MODE_FIELD_W-1:0] s_tuser, // mode[1:0]
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic      [TDATA_W-1:0] m_tdata    // victim_set[7:0], victim_way[10:8], zero pad
);

    localparam int SET_AW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_AW = $clog2(NUM_WAYS);
    localparam int ENT_W  = NUM_WAYS + WAY_AW;

    // set index reduction table: raw field modulo NUM_SETS
    logic [SET_AW-1:0] set_lut [SET_LUT_DEPTH];

    for (genvar g = 0; g < SET_LUT_DEPTH; g++) begin : g_set_lut
        assign set_lut[g] = SET_AW'(g % NUM_SETS);
    end

    // control and item registers
    state_t                  state_reg, state_next;
    logic [SET_AW-1:0]       clr_cnt_reg, clr_cnt_next;
    mode_t                   mode_reg;
    logic [SET_FIELD_W-1:0]  raw_set_reg;
    logic [SET_AW-1:0]       set_reg;
    logic [WAY_FIELD_W-1:0]  way_reg;

    // output register
    logic                    m_valid_reg, m_valid_next;
    logic [SET_FIELD_W-1:0]  out_set_reg;
    logic [WAY_FIELD_W-1:0]  out_way_reg;

    // RAM interface
    logic                    ram_we;
    logic [SET_AW-1:0]       ram_waddr;
    logic [ENT_W-1:0]        ram_wdata;
    logic                    ram_re;
    logic [ENT_W-1:0]        ram_rdata;

    // datapath
    logic                    s_accept;
    logic                    out_load;
    logic [NUM_WAYS-1:0]     cur_bits;
    logic [WAY_AW-1:0]       cur_hand;
    logic [NUM_WAYS-1:0]     rot_bits;
    logic [NUM_WAYS-1:0]     rot_clr;
    logic [NUM_WAYS-1:0]     clr_mask;
    logic                    found;
    logic [WAY_AW-1:0]       first_clr;
    logic [WAY_AW:0]         victim_sum;
    logic [WAY_AW-1:0]       victim;
    logic [WAY_AW:0]         hand_sum;
    logic [WAY_AW-1:0]       new_hand;
    logic [NUM_WAYS-1:0]     new_bits;
    logic [WAY_AW+2:0]       way_ext;
    logic                    way_ok;
    logic [WAY_AW+2:0]       victim_ext;
    logic [NUM_WAYS-1:0]     victim_onehot;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    assign cur_bits = ram_rdata[NUM_WAYS-1:0];
    assign cur_hand = ram_rdata[ENT_W-1:NUM_WAYS];

    // sweep: rotate so the hand sits at bit 0, find the first clear way
    always_comb begin
        logic [2*NUM_WAYS-1:0] dbl;
        logic [2*NUM_WAYS-1:0] dbl_clr;
        dbl      = {cur_bits, cur_bits} >> cur_hand;
        rot_bits = dbl[NUM_WAYS-1:0];
        found     = 1'b0;
        first_clr = '0;
        for (int i = NUM_WAYS - 1; i >= 0; i--) begin
            if (!rot_bits[i]) begin
                found     = 1'b1;
                first_clr = WAY_AW'(i);
            end
        end
        // ways passed by the sweep lose their bit; all of them if none was clear
        for (int i = 0; i < NUM_WAYS; i++) begin
            rot_clr[i] = !found || (WAY_AW'(i) < first_clr);
        end
        dbl_clr  = {rot_clr, rot_clr} << cur_hand;
        clr_mask = dbl_clr[2*NUM_WAYS-1:NUM_WAYS];
    end

    // victim way and advanced hand, both modulo NUM_WAYS
    always_comb begin
        victim_sum = {1'b0, cur_hand} + {1'b0, first_clr};
        if (victim_sum >= (WAY_AW+1)'(NUM_WAYS)) begin
            victim_sum = victim_sum - (WAY_AW+1)'(NUM_WAYS);
        end
        victim   = victim_sum[WAY_AW-1:0];
        hand_sum = {1'b0, victim} + (WAY_AW+1)'(1);
        if (hand_sum >= (WAY_AW+1)'(NUM_WAYS)) begin
            hand_sum = '0;
        end
        new_hand = hand_sum[WAY_AW-1:0];
    end

    assign way_ext    = (WAY_AW+3)'(way_reg);
    assign way_ok     = way_ext < (WAY_AW+3)'(NUM_WAYS);
    assign victim_ext = {3'b000, victim};
    assign victim_onehot = {{(NUM_WAYS-1){1'b0}}, 1'b1} << victim;

    // new reference bits for the operation in flight
    always_comb begin
        new_bits = cur_bits;
        case (mode_reg)
            MODE_TOUCH, MODE_FILL: begin
                for (int j = 0; j < NUM_WAYS; j++) begin
                    if (way_ok && way_ext == (WAY_AW+3)'(j)) begin
                        new_bits[j] = 1'b1;
                    end
                end
            end
            MODE_INVAL: begin
                for (int j = 0; j < NUM_WAYS; j++) begin
                    if (way_ok && way_ext == (WAY_AW+3)'(j)) begin
                        new_bits[j] = 1'b0;
                    end
                end
            end
            MODE_VICTIM: begin
                new_bits = cur_bits & ~clr_mask;
            end
            default: begin
                new_bits = cur_bits;
            end
        endcase
    end

    // controller: next state, RAM strobes, output load
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        ram_we       = 1'b0;
        ram_waddr    = set_reg;
        ram_wdata    = {cur_hand, new_bits};
        ram_re       = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + SET_AW'(1);
                if (clr_cnt_reg == SET_AW'(NUM_SETS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                ram_re = s_accept;
                if (s_accept) begin
                    state_next = ST_MODIFY;
                end
            end
            ST_MODIFY: begin
                if (mode_reg == MODE_VICTIM) begin
                    if (!m_valid_reg || m_tready) begin
                        out_load   = 1'b1;
                        ram_we     = 1'b1;
                        ram_wdata  = {new_hand, new_bits};
                        state_next = ST_IDLE;
                    end
                end else begin
                    ram_we     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid follows load and take
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // item capture on an accepted transaction
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            mode_reg    <= mode_t'(s_tuser);
            raw_set_reg <= s_tdata[SET_FIELD_W-1:0];
            set_reg     <= set_lut[s_tdata[SET_FIELD_W-1:0]];
            way_reg     <= s_tdata[SET_FIELD_W +: WAY_FIELD_W];
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_set_reg <= raw_set_reg;
            out_way_reg <= victim_ext[WAY_FIELD_W-1:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(TDATA_W - SET_FIELD_W - WAY_FIELD_W){1'b0}}, out_way_reg, out_set_reg};

    ccr_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_SETS)
    ) u_state_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (set_lut[s_tdata[SET_FIELD_W-1:0]]),
        .rdata (ram_rdata)
    );

    // an accepted transaction always moves on to the write-back cycle
    a_accept_to_modify: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == ST_MODIFY)
        else $error("accepted transaction did not reach write-back");

    // only a victim request produces a result
    a_load_victim_only: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> mode_reg == MODE_VICTIM)
        else $error("result loaded for a non-victim operation");

    // the chosen victim always leaves with its reference bit clear
    a_victim_bit_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (new_bits & victim_onehot) == '0)
        else $error("victim way still referenced after sweep");

    // the hand written back stays within the ways
    a_hand_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> ram_wdata[ENT_W-1:NUM_WAYS] < WAY_AW'(NUM_WAYS - 1)
                   || ram_wdata[ENT_W-1:NUM_WAYS] == WAY_AW'(NUM_WAYS - 1))
        else $error("clock hand out of range");

endmodule

`default_nettype wire
